// ===== design/ohlcv_pkg.sv =====
// Shared constants and widths for the OHLCV period aggregator.
`timescale 1ns / 1ps
package ohlcv_pkg;
	localparam int PRICE_WIDTH_DEF = 48;
	localparam int COUNT_WIDTH_DEF = 32;
	localparam int TIME_WIDTH = 64;
	localparam int PERIOD_WIDTH = 52;
	localparam logic [PERIOD_WIDTH-1:0] PERIOD_RESET = 52'd60000000000;
endpackage

// ===== design/ohlcv_if.sv =====
// Bar input and period output channel interfaces.
`timescale 1ns / 1ps
interface ohlcv_bar_if #(parameter int PW = 48, parameter int CW = 32);
	logic valid;
	logic ready;
	logic flush;
	logic [63:0] in_time;
	logic [PW-1:0] in_open;
	logic [PW-1:0] in_high;
	logic [PW-1:0] in_low;
	logic [PW-1:0] in_close;
	logic [PW-1:0] in_volume;
	logic [PW-1:0] in_wap;
	logic [CW-1:0] in_trades;
	modport source (output valid, flush, in_time, in_open, in_high, in_low, in_close,
		in_volume, in_wap, in_trades, input ready);
	modport sink (input valid, flush, in_time, in_open, in_high, in_low, in_close,
		in_volume, in_wap, in_trades, output ready);
endinterface

interface ohlcv_run_if #(parameter int PW = 48, parameter int CW = 32);
	logic valid;
	logic ready;
	logic [63:0] out_start;
	logic [PW-1:0] out_open;
	logic [PW-1:0] out_high;
	logic [PW-1:0] out_low;
	logic [PW-1:0] out_close;
	logic [PW-1:0] out_volume;
	logic [PW-1:0] out_wap;
	logic [CW-1:0] out_trades;
	modport source (output valid, out_start, out_open, out_high, out_low, out_close,
		out_volume, out_wap, out_trades, input ready);
	modport sink (input valid, out_start, out_open, out_high, out_low, out_close,
		out_volume, out_wap, out_trades, output ready);
endinterface

// ===== design/ohlcv_div.sv =====
// Radix-2 restoring divider that retires one quotient bit per cycle.
`timescale 1ns / 1ps
module ohlcv_div import ohlcv_pkg::*; #(
	parameter int DW = 128,
	parameter int VW = 64,
	localparam int SW = $clog2(DW + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [SW-1:0] steps,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quotient,
	output logic [VW-1:0] remainder
);
	logic [DW-1:0] num_q;
	logic [DW-1:0] quo_q;
	logic [VW:0]   rem_q;
	logic [VW-1:0] div_q;
	logic [SW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [VW:0]   shifted;
	logic          take;

	assign shifted = {rem_q[VW-1:0], num_q[DW-1]};
	assign take = shifted >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == SW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			quo_q <= '0;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			num_q <= {num_q[DW-2:0], 1'b0};
			quo_q <= {quo_q[DW-2:0], take};
			rem_q <= take ? shifted - {1'b0, div_q} : shifted;
		end
	end

	assign done = done_q;
	assign quotient = quo_q;
	assign remainder = rem_q[VW-1:0];
endmodule

// ===== design/ohlcv_period_aggregator_core.sv =====
// Top level of the OHLCV period aggregator.
// Flow: a bar is accepted in S_IDLE, aligned to its period start by the divider in S_ALIGN and
// then merged into the open run or opened as a new run in S_DECIDE. A bar that merges with a nonzero
// volume then runs a shift-add multiply in S_MUL and a divide in S_DIV to update the WAP; a flush
// passes through S_FLUSH. A held result stalls S_DECIDE or S_FLUSH until the output register is free.
// Reset (arst_n low) clears the open run and the output valid and restores period_q to PERIOD_RESET.
`timescale 1ns / 1ps
module ohlcv_period_aggregator_core import ohlcv_pkg::*; #(
	parameter int PRICE_WIDTH = PRICE_WIDTH_DEF,
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	ohlcv_bar_if.sink               bars,
	ohlcv_run_if.source             runs,
	input  logic                    cfg_we,
	input  logic [PERIOD_WIDTH-1:0] cfg_wdata
);
	localparam int PW = PRICE_WIDTH;
	localparam int CW = COUNT_WIDTH;
	localparam int DW = (2 * PW > TIME_WIDTH) ? 2 * PW : TIME_WIDTH;
	localparam int SW = $clog2(DW + 1);
	localparam int MW = $clog2(PW + 1);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_FLUSH  = 6'b000010,
		S_ALIGN  = 6'b000100,
		S_DECIDE = 6'b001000,
		S_MUL    = 6'b010000,
		S_DIV    = 6'b100000
	} state_t;

	state_t state_q;
	logic [PERIOD_WIDTH-1:0] period_q;

	logic [TIME_WIDTH-1:0] b_time_q;
	logic [PW-1:0] b_open_q, b_high_q, b_low_q, b_close_q, b_vol_q, b_wap_q;
	logic [CW-1:0] b_trades_q;

	logic run_active_q;
	logic [TIME_WIDTH-1:0] run_start_q;
	logic [PW-1:0] run_open_q, run_high_q, run_low_q, run_close_q, run_vol_q, run_wap_q;
	logic [CW-1:0] run_trades_q;
	logic [TIME_WIDTH-1:0] start_q;

	logic [PW-1:0] diff_q;
	logic neg_q;
	logic [2*PW-1:0] prod_q;
	logic [MW-1:0] mcnt_q;

	logic out_valid_q;

	logic div_start, div_done;
	logic [SW-1:0] div_steps;
	logic [DW-1:0] div_dividend, div_quotient;
	logic [TIME_WIDTH-1:0] div_divisor, div_remainder;

	logic in_acc, out_free, same_run, emit;
	logic [PW:0] vol_sum;
	logic [PW-1:0] vol_new;
	logic [CW:0] trd_sum;
	logic [CW-1:0] trd_new;
	logic [PW-1:0] mul_add;
	logic [PW:0] mul_sum;
	logic [PW-1:0] quo;
	logic [PERIOD_WIDTH-1:0] period_eff;

	assign in_acc = bars.valid && bars.ready;
	assign bars.ready = (state_q == S_IDLE);
	assign out_free = !out_valid_q || runs.ready;
	assign same_run = run_active_q && (start_q == run_start_q);
	assign emit = out_free && run_active_q &&
		((state_q == S_FLUSH) || (state_q == S_DECIDE && !same_run));
	assign vol_sum = {1'b0, run_vol_q} + {1'b0, b_vol_q};
	assign vol_new = vol_sum[PW] ? '1 : vol_sum[PW-1:0];
	assign trd_sum = {1'b0, run_trades_q} + {1'b0, b_trades_q};
	assign trd_new = trd_sum[CW] ? '1 : trd_sum[CW-1:0];
	assign mul_add = prod_q[0] ? diff_q : {PW{1'b0}};
	assign mul_sum = {1'b0, prod_q[2*PW-1:PW]} + {1'b0, mul_add};
	assign quo = div_quotient[PW-1:0];
	assign period_eff = (period_q == '0) ? PERIOD_WIDTH'(1) : period_q;

	always_comb begin
		div_start = 1'b0;
		div_steps = SW'(TIME_WIDTH);
		div_dividend = DW'(b_time_q) << (DW - TIME_WIDTH);
		div_divisor = TIME_WIDTH'(period_eff);
		if (in_acc && !bars.flush) begin
			div_start = 1'b1;
			div_dividend = DW'(bars.in_time) << (DW - TIME_WIDTH);
		end else if (state_q == S_MUL && mcnt_q == MW'(1)) begin
			div_start = 1'b1;
			div_steps = SW'(2 * PW);
			div_dividend = DW'({mul_sum, prod_q[PW-1:1]}) << (DW - 2 * PW);
			div_divisor = TIME_WIDTH'(run_vol_q);
		end
	end

	ohlcv_div #(.DW(DW), .VW(TIME_WIDTH)) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.steps(div_steps),
		.dividend(div_dividend),
		.divisor(div_divisor),
		.done(div_done),
		.quotient(div_quotient),
		.remainder(div_remainder)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			period_q <= PERIOD_RESET;
			run_active_q <= 1'b0;
			out_valid_q <= 1'b0;
			mcnt_q <= '0;
		end else begin
			if (cfg_we) begin
				period_q <= cfg_wdata;
			end
			out_valid_q <= emit || (out_valid_q && !runs.ready);
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= bars.flush ? S_FLUSH : S_ALIGN;
					end
				end
				S_FLUSH: begin
					if (!run_active_q) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						run_active_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				S_ALIGN: begin
					if (div_done) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (same_run) begin
						if (b_vol_q != '0 && vol_new != '0) begin
							mcnt_q <= MW'(PW);
							state_q <= S_MUL;
						end else begin
							state_q <= S_IDLE;
						end
					end else if (!run_active_q || out_free) begin
						run_active_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_MUL: begin
					mcnt_q <= mcnt_q - 1'b1;
					if (mcnt_q == MW'(1)) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			b_time_q <= bars.in_time;
			b_open_q <= bars.in_open;
			b_high_q <= bars.in_high;
			b_low_q <= bars.in_low;
			b_close_q <= bars.in_close;
			b_vol_q <= bars.in_volume;
			b_wap_q <= bars.in_wap;
			b_trades_q <= bars.in_trades;
		end
		if (state_q == S_ALIGN && div_done) begin
			start_q <= b_time_q - div_remainder;
		end
		if (emit) begin
			runs.out_start <= run_start_q;
			runs.out_open <= run_open_q;
			runs.out_high <= run_high_q;
			runs.out_low <= run_low_q;
			runs.out_close <= run_close_q;
			runs.out_volume <= run_vol_q;
			runs.out_wap <= run_wap_q;
			runs.out_trades <= run_trades_q;
		end
		if (state_q == S_DECIDE) begin
			if (same_run) begin
				if (b_high_q > run_high_q) begin
					run_high_q <= b_high_q;
				end
				if (b_low_q < run_low_q) begin
					run_low_q <= b_low_q;
				end
				run_close_q <= b_close_q;
				run_vol_q <= vol_new;
				run_trades_q <= trd_new;
				neg_q <= b_wap_q < run_wap_q;
				diff_q <= (b_wap_q < run_wap_q) ? run_wap_q - b_wap_q : b_wap_q - run_wap_q;
				prod_q <= {{PW{1'b0}}, b_vol_q};
			end else if (!run_active_q || out_free) begin
				run_start_q <= start_q;
				run_open_q <= b_open_q;
				run_high_q <= b_high_q;
				run_low_q <= b_low_q;
				run_close_q <= b_close_q;
				run_vol_q <= b_vol_q;
				run_wap_q <= b_wap_q;
				run_trades_q <= b_trades_q;
			end
		end
		if (state_q == S_MUL) begin
			prod_q <= {mul_sum, prod_q[PW-1:1]};
		end
		if (state_q == S_DIV && div_done) begin
			run_wap_q <= neg_q ? run_wap_q - quo : run_wap_q + quo;
		end
	end

	assign runs.valid = out_valid_q;
endmodule

// ===== design/ohlcv_checker.sv =====
// Port-level assertions for the OHLCV period aggregator and their binding.
`timescale 1ns / 1ps
module ohlcv_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         in_valid,
	input logic         in_ready,
	input logic         out_valid,
	input logic         out_ready,
	input logic [63:0]  out_start,
	input logic [63:0]  out_wap
);
	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("Input ready stayed high after an accepted beat.");

	a_result_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("A result appeared without an item in progress.");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("Output valid dropped before its beat was taken.");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_start) && $stable(out_wap))
		else $error("Output payload changed while stalled.");
endmodule

bind ohlcv_period_aggregator_core ohlcv_checker u_ohlcv_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(bars.valid),
	.in_ready(bars.ready),
	.out_valid(runs.valid),
	.out_ready(runs.ready),
	.out_start(runs.out_start),
	.out_wap(64'(runs.out_wap))
);
